// ----- src/isrt_pkg.sv -----
// ----------------------------------------------------------------------------
// isrt_pkg
// Shared widths, defaults and the control struct of the insertion sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package isrt_pkg;

	// width of one list element
	localparam int unsigned DATA_W = 32;

	// default number of cells in the chain
	localparam int unsigned ISRT_MAX_ITEMS = 32;

	// chain-wide commands, broadcast to every cell
	typedef struct packed {
		logic insert;   // place the broadcast value in the chain
		logic pop;      // shift the chain one cell toward the head
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ----- src/isrt_cell.sv -----
// ----------------------------------------------------------------------------
// isrt_cell
// One slot of the sorting chain: holds a value and its occupancy, compares
// against the broadcast value and trades data with its two neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module isrt_cell
	import isrt_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire cell_ctrl_t               ctrl,
	input  wire logic signed [DATA_W-1:0] new_value,
	// neighbor toward the head
	input  wire logic signed [DATA_W-1:0] left_value,
	input  wire logic                     left_valid,
	input  wire logic                     left_take,
	// neighbor toward the tail
	input  wire logic signed [DATA_W-1:0] right_value,
	input  wire logic                     right_valid,
	// own state
	output logic signed [DATA_W-1:0]      value_q,
	output logic                          valid_q,
	output logic                          take
);

	// new value lands here or nearer the head: slot empty or holds a larger value
	always_comb begin
		take = !valid_q || (value_q > new_value);
	end

	// occupancy, a thermometer along the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.pop) begin
			valid_q <= right_valid;
		end else if (ctrl.insert) begin
			valid_q <= valid_q | left_valid;
		end
	end

	// held value: shift toward the tail on insert, toward the head on pop
	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			value_q <= right_value;
		end else if (ctrl.insert && take) begin
			value_q <= left_take ? left_value : new_value;
		end
	end

endmodule

`default_nettype wire

// ----- src/insertion_sorter.sv -----
// ----------------------------------------------------------------------------
// insertion_sorter
// Stable ascending sort of signed values in a chain of compare-and-shift
// cells; the beat flagged final releases the list in order.
// ----------------------------------------------------------------------------
//
//  channel  direction  beat carries                          handshake
//  in       sink       value, is_final                       in_valid / in_ready
//  out      source     sorted_value, end_of_list, overflow   out_valid / out_ready
//
//  Loading takes one input beat per cycle: every cell compares against the
//  incoming value at once and the whole chain shifts together.
//  The final beat switches to draining; the list leaves the head cell one
//  beat per cycle while out_ready is high, and input stays blocked until
//  the last value of the list has left.
//  Values beyond MAX_ITEMS are dropped and mark the whole list as overflow.
//  Reset empties the chain at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module insertion_sorter
	import isrt_pkg::*;
#(
	parameter int unsigned MAX_ITEMS = ISRT_MAX_ITEMS
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic signed [DATA_W-1:0] value,
	input  wire logic                     is_final,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [DATA_W-1:0]      sorted_value,
	output logic                          end_of_list,
	output logic                          overflow
);

	logic signed [DATA_W-1:0] cell_value [MAX_ITEMS];
	logic [MAX_ITEMS-1:0]     cell_valid;
	logic [MAX_ITEMS-1:0]     cell_take;
	cell_ctrl_t               ctrl;
	logic                     draining_q;
	logic                     dropped_q;
	logic                     in_beat;
	logic                     out_beat;
	logic                     full;

	// handshake and chain commands
	always_comb begin
		in_ready    = !draining_q;
		in_beat     = in_valid && in_ready;
		out_valid   = draining_q;
		out_beat    = out_valid && out_ready;
		full        = cell_valid[MAX_ITEMS-1];
		ctrl.insert = in_beat && !full;
		ctrl.pop    = out_beat;
	end

	// result value comes straight from the head cell; end of list when the next cell is empty
	always_comb begin
		sorted_value = cell_value[0];
		end_of_list  = !cell_valid[1];
		overflow     = dropped_q;
	end

	// the chain of cells
	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		logic signed [DATA_W-1:0] l_value;
		logic                     l_valid;
		logic                     l_take;
		logic signed [DATA_W-1:0] r_value;
		logic                     r_valid;

		if (i == 0) begin : g_head
			assign l_value = '0;
			assign l_valid = 1'b1;
			assign l_take  = 1'b0;
		end else begin : g_body
			assign l_value = cell_value[i-1];
			assign l_valid = cell_valid[i-1];
			assign l_take  = cell_take[i-1];
		end

		if (i == MAX_ITEMS - 1) begin : g_tail
			assign r_value = '0;
			assign r_valid = 1'b0;
		end else begin : g_inner
			assign r_value = cell_value[i+1];
			assign r_valid = cell_valid[i+1];
		end

		isrt_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.new_value   (value),
			.left_value  (l_value),
			.left_valid  (l_valid),
			.left_take   (l_take),
			.right_value (r_value),
			.right_valid (r_valid),
			.value_q     (cell_value[i]),
			.valid_q     (cell_valid[i]),
			.take        (cell_take[i])
		);
	end

	// load / drain mode and overflow flag of the current list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draining_q <= 1'b0;
			dropped_q  <= 1'b0;
		end else begin
			if (in_beat && full) begin
				dropped_q <= 1'b1;
			end
			if (in_beat && is_final) begin
				draining_q <= 1'b1;
			end
			if (out_beat && end_of_list) begin
				draining_q <= 1'b0;
				dropped_q  <= 1'b0;
			end
		end
	end

	// occupancy stays a contiguous run from the head
	a_thermo: assert property (@(posedge clk) disable iff (!arst_n)
		((cell_valid + 1'b1) & cell_valid) == '0)
		else $error("chain occupancy has a hole");

	// input and output never both open
	a_mode: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output open together");

	// last beat of a list leaves the chain empty
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_beat && end_of_list) |=> (cell_valid == '0 && !dropped_q))
		else $error("chain not empty after end of list");

	// values are dropped only when the chain is full
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dropped_q) |-> cell_valid[MAX_ITEMS-1])
		else $error("overflow flagged with free cells");

	// a draining chain always holds a value at its head
	a_head: assert property (@(posedge clk) disable iff (!arst_n)
		draining_q |-> cell_valid[0])
		else $error("draining with empty head cell");

endmodule

`default_nettype wire

// ----- sim/sorted_list_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_checker
// Watches both channels of the insertion sorter, keeps its own stable sorted
// list per input list and compares every output beat against it in order.
// ----------------------------------------------------------------------------
module sorted_list_checker
	import isrt_pkg::*;
#(
	parameter int unsigned MAX_ITEMS = ISRT_MAX_ITEMS
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	input  wire logic                     in_ready,
	input  wire logic signed [DATA_W-1:0] value,
	input  wire logic                     is_final,
	input  wire logic                     out_valid,
	input  wire logic                     out_ready,
	input  wire logic signed [DATA_W-1:0] sorted_value,
	input  wire logic                     end_of_list,
	input  wire logic                     overflow,
	output int                            fail_count,
	output int                            pending,
	output int                            result_count
);

	typedef struct packed {
		logic signed [DATA_W-1:0] val;
		logic                     last;
		logic                     ovf;
	} sorted_beat_t;

	// list being collected and beats still owed by the block
	logic signed [DATA_W-1:0] held_list[$];
	logic                     list_dropped = 1'b0;
	sorted_beat_t             owed_beats[$];

	// place v after every held value not greater than it, or drop it when full
	function automatic void insert_stable(input logic signed [DATA_W-1:0] v);
		int slot;
		if (held_list.size() >= MAX_ITEMS) begin
			list_dropped = 1'b1;
			return;
		end
		slot = held_list.size();
		for (int k = 0; k < held_list.size(); k++) begin
			if (held_list[k] > v) begin
				slot = k;
				break;
			end
		end
		held_list.insert(slot, v);
	endfunction

	// the final beat releases the whole list in order
	function automatic void release_list();
		sorted_beat_t b;
		for (int k = 0; k < held_list.size(); k++) begin
			b.val  = held_list[k];
			b.last = (k == held_list.size() - 1);
			b.ovf  = list_dropped;
			owed_beats.push_back(b);
		end
		held_list.delete();
		list_dropped = 1'b0;
	endfunction

	// sample at the falling edge: inputs only move at the rising edge
	always @(negedge clk) begin
		sorted_beat_t want;
		if (arst_n) begin
			// output beat against the oldest owed beat
			if (out_valid && out_ready) begin
				result_count++;
				if (owed_beats.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected output beat, actual value %0d eol %0b ovf %0b",
						$time, sorted_value, end_of_list, overflow);
				end else begin
					want = owed_beats.pop_front();
					if (sorted_value !== want.val) begin
						fail_count++;
						$display("%0t: sorted_value expected %0d actual %0d",
							$time, want.val, sorted_value);
					end
					if (end_of_list !== want.last) begin
						fail_count++;
						$display("%0t: end_of_list expected %0b actual %0b",
							$time, want.last, end_of_list);
					end
					if (overflow !== want.ovf) begin
						fail_count++;
						$display("%0t: overflow expected %0b actual %0b",
							$time, want.ovf, overflow);
					end
				end
			end
			// input beat into the predicted list
			if (in_valid && in_ready) begin
				insert_stable(value);
				if (is_final)
					release_list();
			end
		end
		pending = owed_beats.size();
	end

endmodule

// ----- sim/tb_insertion_sorter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_insertion_sorter
// Drives lists into the insertion sorter: a short directed set of extremes,
// ties and orderings, then random lists of mixed length including full and
// overflowing ones, under three sender/receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_insertion_sorter;
	import isrt_pkg::*;

	localparam int unsigned CELLS        = ISRT_MAX_ITEMS;
	localparam int          STALL_LIMIT  = 4000;
	localparam int          RANDOM_BEATS = 440;
	localparam int          DIRECTED_N   = 16;

	localparam logic signed [DATA_W-1:0] INT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// single top value, mixed extremes with ties, descending run, minimum last
	localparam logic signed [DATA_W-1:0] DIRECTED_VALS [DIRECTED_N] = '{
		INT_MAX,
		0, INT_MIN, INT_MAX, -1, 1, 5, 5, -1,
		3, 2, 1, 0,
		1, 2, INT_MIN
	};
	localparam logic [DIRECTED_N-1:0] DIRECTED_LAST =
		DIRECTED_N'((1 << 0) | (1 << 8) | (1 << 12) | (1 << 15));

	logic                     clk       = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic signed [DATA_W-1:0] value;
	logic                     is_final;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [DATA_W-1:0] sorted_value;
	logic                     end_of_list;
	logic                     overflow;

	int fail_count;
	int pending;
	int result_count;
	int idle_in_pct    = 18;
	int idle_out_pct   = 63;
	int beats_sent     = 0;
	int lists_sent     = 0;
	int overflow_lists = 0;
	int quiet_cycles   = 0;

	always #10 clk = ~clk;

	insertion_sorter u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.value        (value),
		.is_final     (is_final),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sorted_value (sorted_value),
		.end_of_list  (end_of_list),
		.overflow     (overflow)
	);

	sorted_list_checker #(.MAX_ITEMS(CELLS)) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.value        (value),
		.is_final     (is_final),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sorted_value (sorted_value),
		.end_of_list  (end_of_list),
		.overflow     (overflow),
		.fail_count   (fail_count),
		.pending      (pending),
		.result_count (result_count)
	);

	// receiver stalls at the current rate
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= idle_out_pct);
	end

	// watchdog: too long without any beat on either channel
	always @(negedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// one input beat, with random idle cycles ahead of it
	task automatic send_beat(input logic signed [DATA_W-1:0] v, input logic fin);
		logic taken;
		while ($urandom_range(99) < idle_in_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		is_final <= fin;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end
		beats_sent++;
		if (fin)
			lists_sent++;
	endtask

	// hold off until the block has returned every sorted beat
	task automatic wait_drained();
		while (pending != 0)
			@(posedge clk);
	endtask

	// half full-range values, the rest small values for ties and the extremes
	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return $urandom;
			5, 6, 7:       return int'($urandom_range(15)) - 8;
			8:             return $urandom_range(1) ? INT_MAX : INT_MIN;
			default:       return int'($urandom_range(2)) - 1;
		endcase
	endfunction

	// mostly short lists, some long, some exactly full or past capacity
	function automatic int pick_length();
		case ($urandom_range(19))
			14, 15, 16: return $urandom_range(CELLS - 1, 9);
			17:         return CELLS;
			18:         return CELLS + 1;
			19:         return $urandom_range(CELLS + 8, CELLS + 2);
			default:    return $urandom_range(8, 1);
		endcase
	endfunction

	task automatic send_list(input int len);
		for (int k = 0; k < len; k++)
			send_beat(pick_value(), k == len - 1);
		if (len > CELLS)
			overflow_lists++;
	endtask

	initial begin
		int progress;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		value    = '0;
		is_final = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed lists
		for (int i = 0; i < DIRECTED_N; i++)
			send_beat(DIRECTED_VALS[i], DIRECTED_LAST[i]);
		wait_drained();

		// random lists over three stall mixes
		while (beats_sent < DIRECTED_N + RANDOM_BEATS) begin
			progress = beats_sent - DIRECTED_N;
			if (progress < RANDOM_BEATS / 3) begin
				idle_in_pct  = 18;
				idle_out_pct = 63;
			end else if (progress < 2 * RANDOM_BEATS / 3) begin
				idle_in_pct  = 63;
				idle_out_pct = 18;
			end else begin
				idle_in_pct  = 0;
				idle_out_pct = 0;
			end
			send_list(pick_length());
			if ($urandom_range(7) == 0)
				wait_drained();
		end
		in_valid <= 1'b0;

		wait_drained();
		repeat (40) @(posedge clk);

		$display("sent %0d beats in %0d lists (%0d past capacity)",
			beats_sent, lists_sent, overflow_lists);
		$display("checked %0d sorted beats under three stall mixes", result_count);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
